@@ rtl/core/tmle_pkg.sv @@
`default_nettype none
package tmle_pkg;

	localparam int VAL_W      = 16;
	localparam int SQ_W       = 44;
	localparam int LOSS_W     = 38;
	localparam int CNT_W      = 17;
	localparam int IDX_W      = 16;
	localparam int MARGIN_W   = 16;
	localparam int MODE_W     = 2;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int REM_W      = SQ_W + 1;
	localparam int ROOT_W     = 47;
	localparam int DIST_W     = 23;
	localparam int DIFF_W     = DIST_W + 2;
	localparam int DCNT_W     = $clog2(LOSS_W);

	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [SQ_W-1:0]   SQ_MAX   = '1;
	localparam logic [LOSS_W-1:0] LOSS_MAX = '1;
	localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
	localparam logic [REM_W-1:0]  EPS_Q24  = REM_W'(17);
	localparam logic [ROOT_W-1:0] ROOT_BIT_INIT = ROOT_W'(1) << (ROOT_W - 1);

	localparam logic [MARGIN_W-1:0] MARGIN_RST = MARGIN_W'(4096);

	localparam logic [CFG_IDX_W-1:0] REG_MARGIN = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SWAP   = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_MODE   = CFG_IDX_W'(2);

	localparam logic [MODE_W-1:0] MODE_NONE = MODE_W'(0);
	localparam logic [MODE_W-1:0] MODE_MEAN = MODE_W'(1);

	typedef struct packed {
		logic signed [VAL_W-1:0] anchor_value;
		logic signed [VAL_W-1:0] positive_value;
		logic signed [VAL_W-1:0] negative_value;
		logic                    last_feature;
		logic                    last_sample;
	} in_t;

	typedef struct packed {
		logic [LOSS_W-1:0] loss;
		logic [IDX_W-1:0]  sample_index;
	} out_t;

	typedef struct packed {
		logic [SQ_W-1:0] pos_sq;
		logic [SQ_W-1:0] neg_sq;
		logic [SQ_W-1:0] pn_sq;
		logic            last_sample;
	} sample_t;

	typedef struct packed {
		logic [MARGIN_W-1:0] margin;
		logic                swap_enable;
		logic [MODE_W-1:0]   reduction_mode;
	} cfg_t;

	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sq_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQRT,
		ST_FINISH,
		ST_DIV,
		ST_EMIT
	} back_state_t;

	function automatic logic [SQ_W-1:0] sq_acc(input logic [SQ_W-1:0] acc,
			input logic signed [VAL_W-1:0] x, input logic signed [VAL_W-1:0] y);
		logic signed [VAL_W:0] d;
		logic [VAL_W:0]        neg;
		logic [VAL_W-1:0]      m;
		logic [2*VAL_W-1:0]    p;
		logic [SQ_W:0]         s;
		d   = {x[VAL_W-1], x} - {y[VAL_W-1], y};
		neg = -d;
		m   = d[VAL_W] ? neg[VAL_W-1:0] : d[VAL_W-1:0];
		p   = (2*VAL_W)'(m) * (2*VAL_W)'(m);
		s   = {1'b0, acc} + (SQ_W+1)'(p);
		return s[SQ_W] ? SQ_MAX : s[SQ_W-1:0];
	endfunction

	function automatic sq_t sqrt_step(input sq_t s, input logic [ROOT_W-1:0] b);
		logic [ROOT_W-1:0] trial;
		sq_t r;
		trial = s.root + b;
		r     = s;
		if ({{(ROOT_W-REM_W){1'b0}}, s.rem} >= trial) begin
			r.rem  = s.rem - trial[REM_W-1:0];
			r.root = (s.root >> 1) + b;
		end else begin
			r.root = s.root >> 1;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/tmle_front.sv @@
`default_nettype none
module tmle_front (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              item_valid,
	output logic             item_ready,
	input  tmle_pkg::in_t    item,
	output logic             push,
	output tmle_pkg::sample_t push_data,
	input  wire              full
);
	import tmle_pkg::*;

	logic [SQ_W-1:0] pos_q, neg_q, pn_q;
	logic [SQ_W-1:0] pos_nx, neg_nx, pn_nx;
	logic            accept;

	assign item_ready = !full;
	assign accept     = item_valid && item_ready;

	assign pos_nx = sq_acc(pos_q, item.anchor_value, item.positive_value);
	assign neg_nx = sq_acc(neg_q, item.anchor_value, item.negative_value);
	assign pn_nx  = sq_acc(pn_q, item.positive_value, item.negative_value);

	assign push      = accept && item.last_feature;
	assign push_data = '{pos_sq: pos_nx, neg_sq: neg_nx, pn_sq: pn_nx,
		last_sample: item.last_sample};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			neg_q <= '0;
			pn_q  <= '0;
		end else if (accept) begin
			if (item.last_feature) begin
				pos_q <= '0;
				neg_q <= '0;
				pn_q  <= '0;
			end else begin
				pos_q <= pos_nx;
				neg_q <= neg_nx;
				pn_q  <= pn_nx;
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/tmle_queue.sv @@
`default_nettype none
module tmle_queue #(
	parameter int DEPTH = tmle_pkg::QUEUE_DEPTH_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               push,
	input  tmle_pkg::sample_t push_data,
	output logic              full,
	input  wire               pop,
	output tmle_pkg::sample_t pop_data,
	output logic              empty
);
	import tmle_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W_Q = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0]   LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W_Q-1:0] FULL_CNT = CNT_W_Q'(DEPTH);

	sample_t            mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W_Q-1:0] count_q;

	assign full     = (count_q == FULL_CNT);
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W_Q'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W_Q'(1);
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/tmle_back.sv @@
`default_nettype none
module tmle_back (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               empty,
	input  tmle_pkg::sample_t pop_data,
	output logic              pop,
	input  tmle_pkg::cfg_t    cfg,
	output logic              result_valid,
	input  wire               result_ready,
	output tmle_pkg::out_t    result
);
	import tmle_pkg::*;

	back_state_t       state_q, state_nx;
	sq_t               lane_q [3];
	sq_t               lane_nx [3];
	logic [ROOT_W-1:0] bit_q;
	logic              last_s_q;
	logic [CNT_W-1:0]  count_q;
	logic [LOSS_W-1:0] total_q;
	out_t              pend_q;
	logic [LOSS_W-1:0] quo_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  div_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic              out_valid_q;
	out_t              out_q;
	logic              out_load;

	logic [DIST_W-1:0] dpos, dneg, dpn, dneg_sel;
	logic [DIFF_W-1:0] diff;
	logic [LOSS_W-1:0] loss;
	logic [CNT_W-1:0]  count_inc;
	logic [LOSS_W:0]   total_sum;
	logic [LOSS_W-1:0] total_sat;
	logic              mode_none;
	logic [CNT_W:0]    trial;
	logic              ge;
	logic [CNT_W:0]    rem_nx;
	logic [LOSS_W-1:0] quo_nx;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			lane_nx[i] = sqrt_step(lane_q[i], bit_q);
		end
	end

	assign dpos      = lane_q[0].root[DIST_W-1:0];
	assign dneg      = lane_q[1].root[DIST_W-1:0];
	assign dpn       = lane_q[2].root[DIST_W-1:0];
	assign dneg_sel  = (cfg.swap_enable && dpn < dneg) ? dpn : dneg;
	assign diff      = DIFF_W'(dpos) - DIFF_W'(dneg_sel) + DIFF_W'(cfg.margin);
	assign loss      = diff[DIFF_W-1] ? '0 : LOSS_W'(diff);
	assign count_inc = (count_q == CNT_MAX) ? count_q : count_q + CNT_W'(1);
	assign total_sum = {1'b0, total_q} + {1'b0, loss};
	assign total_sat = total_sum[LOSS_W] ? LOSS_MAX : total_sum[LOSS_W-1:0];
	assign mode_none = (cfg.reduction_mode == MODE_NONE);

	assign trial  = {rem_q, quo_q[LOSS_W-1]};
	assign ge     = (trial >= {1'b0, div_q});
	assign rem_nx = ge ? trial - {1'b0, div_q} : trial;
	assign quo_nx = {quo_q[LOSS_W-2:0], ge};

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (!empty) state_nx = ST_SQRT;
			end
			ST_SQRT: begin
				if (bit_q[0]) state_nx = ST_FINISH;
			end
			ST_FINISH: begin
				if (mode_none) state_nx = ST_EMIT;
				else if (!last_s_q) state_nx = ST_IDLE;
				else if (cfg.reduction_mode == MODE_MEAN) state_nx = ST_DIV;
				else state_nx = ST_EMIT;
			end
			ST_DIV: begin
				if (dcnt_q == '0) state_nx = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_load) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: pop      = !empty;
			ST_EMIT: out_load = !out_valid_q || result_ready;
			default: begin
				pop      = 1'b0;
				out_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_FINISH) begin
				count_q <= last_s_q ? '0 : count_inc;
				if (!mode_none) begin
					total_q <= last_s_q ? '0 : total_sat;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				lane_q[0] <= '{rem: {1'b0, pop_data.pos_sq} + EPS_Q24, root: '0};
				lane_q[1] <= '{rem: {1'b0, pop_data.neg_sq} + EPS_Q24, root: '0};
				lane_q[2] <= '{rem: {1'b0, pop_data.pn_sq} + EPS_Q24, root: '0};
				bit_q     <= ROOT_BIT_INIT;
				last_s_q  <= pop_data.last_sample;
			end
			ST_SQRT: begin
				for (int i = 0; i < 3; i++) begin
					lane_q[i] <= lane_nx[i];
				end
				bit_q <= bit_q >> 2;
			end
			ST_FINISH: begin
				if (mode_none) begin
					pend_q <= '{loss: loss, sample_index: count_q[IDX_W-1:0]};
				end else begin
					pend_q <= '{loss: total_sat, sample_index: '0};
				end
				quo_q  <= total_sat;
				rem_q  <= '0;
				div_q  <= count_inc;
				dcnt_q <= DCNT_W'(LOSS_W - 1);
			end
			ST_DIV: begin
				quo_q       <= quo_nx;
				rem_q       <= rem_nx[CNT_W-1:0];
				dcnt_q      <= dcnt_q - DCNT_W'(1);
				pend_q.loss <= quo_nx;
			end
			default: begin
				if (out_load) out_q <= pend_q;
			end
		endcase
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule
`default_nettype wire

@@ rtl/core/triplet_margin_loss_euclidean.sv @@
// channel  | handshake                  | payload
// item     | item_valid / item_ready    | item   (anchor, positive, negative, last flags)
// result   | result_valid / result_ready| result (loss, sample_index)
// config   | wr_en                      | wr_index, wr_data
//
// The front takes one item per cycle while the queue is not full and accumulates
// squares; a sample end enters a queue of QUEUE_DEPTH entries. The back takes one
// sample at a time (pop, 24 square root steps, finish), divides for a mean, and
// loads the output register. item_ready drops only while the queue is full.
// arst_n clears sums, counters, queue and output valid; registers take defaults.
`default_nettype none
module triplet_margin_loss_euclidean #(
	parameter int QUEUE_DEPTH = tmle_pkg::QUEUE_DEPTH_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 item_valid,
	output logic                                item_ready,
	input  tmle_pkg::in_t                       item,
	output logic                                result_valid,
	input  wire                                 result_ready,
	output tmle_pkg::out_t                      result,
	input  wire                                 wr_en,
	input  wire [tmle_pkg::CFG_IDX_W-1:0]       wr_index,
	input  wire [tmle_pkg::CFG_DATA_W-1:0]      wr_data
);
	import tmle_pkg::*;

	cfg_t    cfg_q;
	logic    push, pop, full, empty;
	sample_t push_data, pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{margin: MARGIN_RST, swap_enable: 1'b0, reduction_mode: MODE_MEAN};
		end else if (wr_en) begin
			case (wr_index)
				REG_MARGIN: cfg_q.margin         <= wr_data[MARGIN_W-1:0];
				REG_SWAP:   cfg_q.swap_enable    <= wr_data[0];
				REG_MODE:   cfg_q.reduction_mode <= wr_data[MODE_W-1:0];
				default:    cfg_q <= cfg_q;
			endcase
		end
	end

	tmle_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.push       (push),
		.push_data  (push_data),
		.full       (full)
	);

	tmle_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	tmle_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (empty),
		.pop_data     (pop_data),
		.pop          (pop),
		.cfg          (cfg_q),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
`default_nettype wire

@@ rtl/core/tmle_checker.sv @@
`default_nettype none
module tmle_checker (
	input wire            clk,
	input wire            arst_n,
	input wire            item_valid,
	input wire            item_ready,
	input tmle_pkg::in_t  item,
	input wire            result_valid,
	input wire            result_ready,
	input tmle_pkg::out_t result
);
	import tmle_pkg::*;

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result dropped or changed while stalled");

	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !result_valid)
		else $error("result valid during reset");

	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(item_ready) |-> $past(item_valid && item.last_feature))
		else $error("item_ready fell without a sample end");

endmodule

bind triplet_margin_loss_euclidean tmle_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_ready   (item_ready),
	.item         (item),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);
`default_nettype wire

@@ tb/tb_triplet_margin_loss_euclidean_chk.sv @@
`default_nettype none
module tb_triplet_margin_loss_euclidean_chk (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 item_valid,
	input  wire                 item_ready,
	input  tmle_pkg::in_t       item,
	input  wire                 result_valid,
	input  wire                 result_ready,
	input  tmle_pkg::out_t      result,
	input  wire                 wr_en,
	input  wire [1:0]           wr_index,
	input  wire [15:0]          wr_data,
	output int                  error_count,
	output int                  pending_losses
);
	timeunit 1ns;
	timeprecision 1ps;
	import tmle_pkg::*;

	logic [MARGIN_W-1:0] cfg_margin;
	logic                cfg_swap;
	logic [MODE_W-1:0]   cfg_mode;
	logic [SQ_W-1:0]     acc_ap, acc_an, acc_pn;
	logic [LOSS_W-1:0]   batch_total;
	logic [CNT_W-1:0]    samples_seen;
	out_t                loss_queue[$];

	assign pending_losses = loss_queue.size();

	function automatic logic [SQ_W-1:0] add_square(logic [SQ_W-1:0] acc,
			logic signed [VAL_W-1:0] x, logic signed [VAL_W-1:0] y);
		longint d;
		longint unsigned s;
		d = longint'(x) - longint'(y);
		s = longint'(acc) + d * d;
		return (s > longint'(SQ_MAX)) ? SQ_MAX : s[SQ_W-1:0];
	endfunction

	function automatic longint unsigned int_root(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 46;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	task automatic report(string what, longint unsigned got, longint unsigned want);
		$display("%0t mismatch %s got %0d want %0d", $realtime, what, got, want);
		error_count++;
	endtask

	task automatic predict_loss(in_t t);
		longint unsigned dp, dn, dx, total;
		longint diff;
		logic [LOSS_W-1:0] l;
		out_t o;
		logic [CNT_W-1:0] idx;
		acc_ap = add_square(acc_ap, t.anchor_value, t.positive_value);
		acc_an = add_square(acc_an, t.anchor_value, t.negative_value);
		acc_pn = add_square(acc_pn, t.positive_value, t.negative_value);
		if (!t.last_feature)
			return;
		dp = int_root(longint'(acc_ap) + 17);
		dn = int_root(longint'(acc_an) + 17);
		dx = int_root(longint'(acc_pn) + 17);
		acc_ap = 0;
		acc_an = 0;
		acc_pn = 0;
		if (cfg_swap && dx < dn)
			dn = dx;
		diff = longint'(dp) - longint'(dn) + longint'(cfg_margin);
		l = diff > 0 ? diff[LOSS_W-1:0] : '0;
		idx = samples_seen;
		if (samples_seen != CNT_MAX)
			samples_seen++;
		if (cfg_mode == MODE_NONE) begin
			o.loss = l;
			o.sample_index = idx[IDX_W-1:0];
			loss_queue.push_back(o);
			if (t.last_sample)
				samples_seen = 0;
			return;
		end
		total = longint'(batch_total) + longint'(l);
		batch_total = total > longint'(LOSS_MAX) ? LOSS_MAX : total[LOSS_W-1:0];
		if (!t.last_sample)
			return;
		o.loss = (cfg_mode == MODE_MEAN) ? LOSS_W'(batch_total / samples_seen) : batch_total;
		o.sample_index = '0;
		loss_queue.push_back(o);
		batch_total = 0;
		samples_seen = 0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_margin = MARGIN_RST;
			cfg_swap = 1'b0;
			cfg_mode = MODE_MEAN;
			acc_ap = 0;
			acc_an = 0;
			acc_pn = 0;
			batch_total = 0;
			samples_seen = 0;
			loss_queue.delete();
			error_count = 0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_MARGIN: cfg_margin = wr_data;
					REG_SWAP:   cfg_swap = wr_data[0];
					REG_MODE:   cfg_mode = wr_data[1:0];
					default: ;
				endcase
			end
			if (item_valid && item_ready)
				predict_loss(item);
			if (result_valid && result_ready) begin
				if (loss_queue.size() == 0) begin
					report("unexpected result", result.loss, 0);
				end else begin
					out_t w;
					w = loss_queue.pop_front();
					if (result.loss !== w.loss)
						report("loss", result.loss, w.loss);
					if (result.sample_index !== w.sample_index)
						report("sample_index", result.sample_index, w.sample_index);
				end
			end
		end
	end
endmodule
`default_nettype wire

@@ tb/tb_triplet_margin_loss_euclidean.sv @@
`default_nettype none
module tb_triplet_margin_loss_euclidean;
	timeunit 1ns;
	timeprecision 1ps;
	import tmle_pkg::*;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       item_valid = 1'b0;
	logic       item_ready;
	in_t        item = '0;
	logic       result_valid;
	logic       result_ready = 1'b0;
	out_t       result;
	logic       wr_en = 1'b0;
	logic [1:0] wr_index = '0;
	logic [15:0] wr_data = '0;
	int         error_count;
	int         pending_losses;
	int         idle_cycles = 0;
	bit         long_hold = 1'b0;
	bit         stim_done = 1'b0;

	localparam int WATCHDOG_LIMIT = 20000;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	triplet_margin_loss_euclidean DUT (
		.clk, .arst_n, .item_valid, .item_ready, .item, .result_valid,
		.result_ready, .result, .wr_en, .wr_index, .wr_data
	);

	tb_triplet_margin_loss_euclidean_chk checker_inst (
		.clk, .arst_n, .item_valid, .item_ready, .item, .result_valid,
		.result_ready, .result, .wr_en, .wr_index, .wr_data,
		.error_count, .pending_losses
	);

	function automatic logic signed [15:0] pick_value(int kind);
		case (kind)
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'sh0000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_item(in_t t);
		item <= t;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
	endtask

	task automatic gap_or_continue();
		if ($urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic send_sample(int nfeat, bit last_s, int vals);
		in_t t;
		for (int f = 0; f < nfeat; f++) begin
			t.anchor_value = pick_value(vals == 0 ? $urandom_range(0, 3) : vals);
			t.positive_value = pick_value(vals == 0 ? $urandom_range(0, 3) : vals);
			t.negative_value = pick_value(vals == 0 ? $urandom_range(0, 3) : vals);
			if (vals == 1) begin
				t.positive_value = 16'sh8000;
				t.negative_value = 16'sh7fff;
			end
			t.last_feature = (f == nfeat - 1);
			t.last_sample = (f == nfeat - 1) ? last_s : $urandom_range(0, 1);
			send_item(t);
			gap_or_continue();
		end
	endtask

	task automatic drain_and_write(logic [1:0] idx, logic [15:0] data);
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_losses != 0)
			@(posedge clk);
		repeat (120) @(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic set_config(logic [15:0] m, bit s, logic [1:0] mode);
		drain_and_write(REG_MARGIN, m);
		drain_and_write(REG_SWAP, {15'd0, s});
		drain_and_write(REG_MODE, {14'd0, mode});
	endtask

	task automatic random_batches(int nitems);
		int sent;
		int nf;
		sent = 0;
		while (sent < nitems) begin
			nf = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
			send_sample(nf, $urandom_range(0, 3) == 0, 0);
			sent += nf;
		end
	endtask

	always @(posedge clk) begin
		if (long_hold)
			result_ready <= 1'b0;
		else
			result_ready <= ($urandom_range(0, 7) < 3) ? 1'b0 : (($urandom & 32'h100) == 0 ||
				$urandom_range(0, 1) == 1);
	end

	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready) || wr_en)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_sample(1, 1'b0, 2);
		send_sample(2, 1'b1, 3);
		send_sample(3, 1'b1, 1);
		set_config(16'd0, 1'b1, MODE_NONE);
		send_sample(1, 1'b0, 1);
		send_sample(2, 1'b1, 3);
		send_sample(64, 1'b1, 1);
		long_hold = 1'b1;
		send_sample(12, 1'b0, 0);
		fork
			begin
				repeat (300) @(posedge clk);
				long_hold = 1'b0;
			end
			begin
				repeat (8) send_sample(2, 1'b0, 0);
				send_sample(6, 1'b1, 0);
			end
		join
		set_config(16'hffff, 1'b0, 2'd2);
		random_batches(350);
		send_sample(1, 1'b1, 0);
		set_config(16'hffff, 1'b1, 2'd3);
		random_batches(250);
		send_sample(1, 1'b1, 0);
		set_config(16'd4096, 1'b0, MODE_MEAN);
		random_batches(350);
		send_sample(1, 1'b1, 0);
		set_config(16'($urandom), 1'b1, MODE_NONE);
		random_batches(350);
		set_config(16'd0, 1'b0, MODE_MEAN);
		random_batches(300);
		send_sample(1, 1'b1, 0);
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_losses != 0)
			@(posedge clk);
		repeat (150) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
`default_nettype wire

@@ filelist.f @@
rtl/core/tmle_pkg.sv
rtl/core/tmle_front.sv
rtl/core/tmle_queue.sv
rtl/core/tmle_back.sv
rtl/core/triplet_margin_loss_euclidean.sv
rtl/core/tmle_checker.sv
tb/tb_triplet_margin_loss_euclidean_chk.sv
tb/tb_triplet_margin_loss_euclidean.sv
